/* design/range_order_statistics_unit_defines.svh */
// Assertion macros shared by the range order statistics design.
// No dependencies; included by the module that asserts.
`ifndef RANGE_ORDER_STATISTICS_UNIT_DEFINES_SVH
`define RANGE_ORDER_STATISTICS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ROS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("range order statistics check failed");

// Next-cycle implication, checked outside reset.
`define ROS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("range order statistics check failed");

`endif

/* design/ros_pkg.sv */
// Shared types and constants for the range order statistics unit.
// No dependencies.
package ros_pkg;

   localparam int VAL_W          = 27;
   localparam int POS_W          = 8;
   localparam int ACT_W          = 3;
   localparam int BIT_W          = 5;
   localparam int ELEMENTS_DEF   = 256;
   localparam int VALUE_MAX_DEF  = 100000000;

   typedef enum logic [ACT_W-1:0] {
      ACT_WRITE = 3'd0,
      ACT_RANK  = 3'd1,
      ACT_KTH   = 3'd2,
      ACT_PRED  = 3'd3,
      ACT_SUCC  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Broadcast controls for every cell of the ring.
   typedef struct packed {
      logic             shift;
      logic             write;
      logic [VAL_W-1:0] write_data;
   } cell_ctrl_type;

endpackage

/* design/ros_cell.sv */
// One storage cell of the value ring: holds one element value.
// Depends on ros_pkg.
module ros_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  ros_pkg::cell_ctrl_type     ctrl,
   input  logic                       select,
   input  logic [ros_pkg::VAL_W-1:0]  neighbor_value,
   output logic [ros_pkg::VAL_W-1:0]  value
);
   import ros_pkg::*;

   logic [VAL_W-1:0] value_ff, value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.shift) begin
         value_in = neighbor_value;
      end else if (ctrl.write && select) begin
         value_in = ctrl.write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

/* design/range_order_statistics_unit.sv */
// Range order statistics unit: top level with the query sequencer.
// Depends on ros_pkg, ros_cell and range_order_statistics_unit_defines.svh.
//
// Element values sit in a ring of ELEMENTS cells. A query turns the ring,
// one element per cycle, past a single compare unit at cell 0; after a
// full turn every value is home again. A write leaves busy low. Rank,
// predecessor and successor keep busy high for one ring turn and a finish
// state, and the result strobe rises at the same edge where busy falls. A k-th
// query keeps busy high for one ring turn and finish state per answer bit of a
// binary search on value; when k is zero or exceeds the range size busy stays
// low and the result strobe comes in the cycle after acceptance.
// Results are strobed on rsp_valid for one cycle and cannot be held off.
module range_order_statistics_unit #(
   parameter int ELEMENTS  = ros_pkg::ELEMENTS_DEF,
   parameter int VALUE_MAX = ros_pkg::VALUE_MAX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [ros_pkg::ACT_W-1:0]  req_action,
   input  logic [ros_pkg::POS_W-1:0]  req_first_position,
   input  logic [ros_pkg::POS_W-1:0]  req_last_position,
   input  logic [ros_pkg::VAL_W-1:0]  req_operand_value,
   output logic                       rsp_valid,
   output logic [ros_pkg::VAL_W-1:0]  rsp_answer,
   output logic                       rsp_found
);
   import ros_pkg::*;
   `include "range_order_statistics_unit_defines.svh"

   localparam int PW    = (ELEMENTS > 2) ? $clog2(ELEMENTS) : 1;
   localparam int CW    = (PW > POS_W) ? PW : POS_W;
   localparam int CNT_W = $clog2(ELEMENTS + 1);
   localparam logic [CW:0]      ELEM_N    = (CW+1)'(ELEMENTS);
   localparam logic [CW:0]      ELEM_LAST = (CW+1)'(ELEMENTS - 1);
   localparam logic [PW-1:0]    STEP_LAST = PW'(ELEMENTS - 1);
   localparam logic [VAL_W-1:0] VMAX      = VAL_W'(VALUE_MAX);

   // ring
   cell_ctrl_type    ctrl;
   logic [VAL_W-1:0] cell_value [ELEMENTS];
   logic [PW-1:0]    wr_index;

   for (genvar g = 0; g < ELEMENTS; g++) begin : g_cell
      ros_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .select         (wr_index == PW'(g)),
         .neighbor_value (cell_value[(g + 1) % ELEMENTS]),
         .value          (cell_value[g])
      );
   end

   state_type        state_ff, state_in;
   action_type       act_ff, act_in;
   logic [PW-1:0]    step_ff, step_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [VAL_W-1:0] best_ff, best_in;
   logic             have_ff, have_in;
   logic [VAL_W-1:0] t_ff, t_in;
   logic [VAL_W-1:0] key_ff, key_in;
   logic [CW-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_answer_ff, rsp_answer_in;
   logic             rsp_found_ff, rsp_found_in;

   logic             accept;
   logic             scan_start;
   logic [CW:0]      lo_ext, hi_ext;
   logic [CW-1:0]    hi_clamp;
   logic [CW:0]      size_wide;
   logic [CNT_W-1:0] size;
   logic [VAL_W-1:0] trial, cmp_key, head, t_next;
   logic             in_range;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign scan_start = accept && (req_action == ACT_RANK || req_action == ACT_PRED ||
                                  req_action == ACT_SUCC);
   assign lo_ext = (CW+1)'(req_first_position);
   assign hi_ext = (CW+1)'(req_last_position);
   assign hi_clamp = (hi_ext >= ELEM_N) ? ELEM_LAST[CW-1:0] : hi_ext[CW-1:0];
   assign size_wide = (lo_ext[CW-1:0] <= hi_clamp) ?
                      ((CW+1)'(hi_clamp) - lo_ext + (CW+1)'(1)) : '0;
   assign size     = size_wide[CNT_W-1:0];
   assign wr_index = lo_ext[PW-1:0];
   assign trial    = t_ff | (VAL_W'(1) << bit_ff);
   assign cmp_key  = (act_ff == ACT_KTH) ? trial : key_ff;
   assign head     = cell_value[0];
   assign in_range = (CW'(step_ff) >= lo_ff) && (CW'(step_ff) <= hi_ff);
   assign t_next   = (VAL_W'(cnt_ff) < key_ff) ? trial : t_ff;

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      step_in       = step_ff;
      bit_in        = bit_ff;
      cnt_in        = cnt_ff;
      best_in       = best_ff;
      have_in       = have_ff;
      t_in          = t_ff;
      key_in        = key_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rsp_valid_in  = 1'b0;
      rsp_answer_in = rsp_answer_ff;
      rsp_found_in  = rsp_found_ff;
      ctrl.shift      = 1'b0;
      ctrl.write      = 1'b0;
      ctrl.write_data = (req_operand_value > VMAX) ? VMAX : req_operand_value;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in  = action_type'(req_action);
               key_in  = req_operand_value;
               lo_in   = lo_ext[CW-1:0];
               hi_in   = hi_clamp;
               step_in = '0;
               bit_in  = BIT_W'(VAL_W - 1);
               cnt_in  = '0;
               have_in = 1'b0;
               best_in = '0;
               t_in    = '0;
               unique case (req_action)
                  ACT_WRITE: ctrl.write = (lo_ext < ELEM_N);
                  ACT_RANK, ACT_PRED, ACT_SUCC: state_in = ST_SCAN;
                  ACT_KTH: begin
                     if (req_operand_value == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_answer_in = '0;
                        rsp_found_in  = 1'b0;
                     end else if (req_operand_value > VAL_W'(size)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_answer_in = VMAX;
                        rsp_found_in  = 1'b0;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            ctrl.shift = 1'b1;
            step_in    = step_ff + PW'(1);
            if (step_ff == STEP_LAST) begin
               step_in  = '0;
               state_in = ST_FINISH;
            end
            if (in_range) begin
               case (act_ff)
                  ACT_PRED: begin
                     if (head < key_ff && (!have_ff || head > best_ff)) begin
                        best_in = head;
                        have_in = 1'b1;
                     end
                  end
                  ACT_SUCC: begin
                     if (head > key_ff && (!have_ff || head < best_ff)) begin
                        best_in = head;
                        have_in = 1'b1;
                     end
                  end
                  default: begin
                     if (head < cmp_key) cnt_in = cnt_ff + CNT_W'(1);
                  end
               endcase
            end
         end
         ST_FINISH: begin
            case (act_ff)
               ACT_KTH: begin
                  t_in = t_next;
                  if (bit_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_answer_in = t_next;
                     rsp_found_in  = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     bit_in   = bit_ff - BIT_W'(1);
                     cnt_in   = '0;
                     state_in = ST_SCAN;
                  end
               end
               ACT_RANK: begin
                  rsp_valid_in  = 1'b1;
                  rsp_answer_in = VAL_W'(cnt_ff) + VAL_W'(1);
                  rsp_found_in  = 1'b1;
                  state_in      = ST_IDLE;
               end
               default: begin
                  rsp_valid_in  = 1'b1;
                  rsp_answer_in = have_ff ? best_ff : '0;
                  rsp_found_in  = have_ff;
                  state_in      = ST_IDLE;
               end
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      bit_ff        <= bit_in;
      cnt_ff        <= cnt_in;
      best_ff       <= best_in;
      have_ff       <= have_in;
      t_ff          <= t_in;
      key_ff        <= key_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = rsp_answer_ff;
   assign rsp_found  = rsp_found_ff;

   `ROS_ASSERT_NEXT(a_query_goes_busy, scan_start, busy)
   `ROS_ASSERT_IMPL(a_rsp_when_idle, rsp_valid_ff, state_ff != ST_SCAN)
   `ROS_ASSERT_NEXT(a_turn_ends, state_ff == ST_SCAN && step_ff == STEP_LAST, state_ff == ST_FINISH)
   `ROS_ASSERT_IMPL(a_step_home, state_ff != ST_SCAN, step_ff == '0)

endmodule
